[sv/xrpc_pkg.sv]
// Shared types and constants of the XOR range pair counter.
// Used by the channel interfaces, the trie engine, the top level and the checker.
// No dependencies.
package xrpc_pkg;

  // Fixed field widths of the channels.
  localparam int KEY_W      = 16;
  localparam int BOUND_W    = 16;
  localparam int LIM_W      = BOUND_W + 1;
  localparam int CNT_OUT_W  = 10;
  localparam int TOT_W      = 19;
  localparam int CFG_IDX_W  = 1;

  localparam logic [TOT_W-1:0]   TOTAL_MAX  = {TOT_W{1'b1}};
  localparam logic [BOUND_W-1:0] LOW_RESET  = 16'd1;
  localparam logic [BOUND_W-1:0] HIGH_RESET = 16'hFFFF;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_LOW_BOUND  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_BOUND = 1'b1;

  // Command from the top level to the trie engine.
  typedef struct packed {
    logic               start;
    logic               restart;
    logic               res_ack;
    logic [LIM_W-1:0]   hi_lim;
    logic [BOUND_W-1:0] lo_lim;
  } xrpc_cmd_t;

  // Status from the trie engine to the top level.
  typedef struct packed {
    logic idle;
    logic done;
    logic full;
  } xrpc_stat_t;

endpackage

[sv/xrpc_ifs.sv]
// Valid/ready channel interfaces: input items, result items and register writes.
// Depends on xrpc_pkg for the field widths.
interface xrpc_in_if import xrpc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] key_value;
  logic             restart;

  modport source (output valid, key_value, restart, input ready);
  modport sink   (input valid, key_value, restart, output ready);
endinterface

interface xrpc_out_if import xrpc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CNT_OUT_W-1:0] pair_count;
  logic [TOT_W-1:0]     total_pairs;
  logic                 store_full;

  modport source (output valid, pair_count, total_pairs, store_full, input ready);
  modport sink   (input valid, pair_count, total_pairs, store_full, output ready);
endinterface

interface xrpc_cfg_if import xrpc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [BOUND_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[sv/xrpc_trie_engine.sv]
// Trie engine: node link and node count memories, root links and the sequencer
// that runs the two range walks and the insertion. Depends on xrpc_pkg.
module xrpc_trie_engine import xrpc_pkg::*; #(
  parameter int KEY_BITS  = 16,
  parameter int MAX_ITEMS = 1024
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  xrpc_cmd_t                             cmd,
  input  logic [KEY_BITS-1:0]                   key,
  output xrpc_stat_t                            stat,
  output logic [$clog2(MAX_ITEMS+1)-1:0]        hi_cnt,
  output logic [$clog2(MAX_ITEMS+1)-1:0]        lo_cnt
);

  localparam int NODE_DEPTH = MAX_ITEMS * KEY_BITS;
  localparam int NODE_W     = $clog2(NODE_DEPTH + 1);
  localparam int AW         = $clog2(NODE_DEPTH);
  localparam int CNT_W      = $clog2(MAX_ITEMS + 1);
  localparam int LVL_W      = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
  localparam int LX_W       = (KEY_BITS > LIM_W) ? KEY_BITS : LIM_W;
  localparam logic [LVL_W-1:0] TOP_LVL = LVL_W'(KEY_BITS - 1);

  typedef logic [1:0][NODE_W-1:0] links_t;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_SETUP  = 9'b000000010,
    S_WALK   = 9'b000000100,
    S_WTAIL  = 9'b000001000,
    S_INSCHK = 9'b000010000,
    S_INS    = 9'b000100000,
    S_UPD    = 9'b001000000,
    S_ALLOC  = 9'b010000000,
    S_DONE   = 9'b100000000
  } eng_state_t;

  function automatic logic [AW-1:0] node_addr(input logic [NODE_W-1:0] n);
    logic [NODE_W-1:0] m;
    m = n - NODE_W'(1);
    return m[AW-1:0];
  endfunction

  // Node memories: node n lives at address n-1; node 0 is the root, kept in registers.
  links_t           link_mem [NODE_DEPTH];
  logic [CNT_W-1:0] cnt_mem  [NODE_DEPTH];

  links_t           lk_rd_r;
  logic [CNT_W-1:0] ct_rd_r;
  logic             lk_we, lk_re, ct_we, ct_re;
  logic [AW-1:0]    lk_addr, ct_addr;
  links_t           lk_wd;
  logic [CNT_W-1:0] ct_wd;

  always_ff @(posedge clk) begin
    if (lk_we) link_mem[lk_addr] <= lk_wd;
    if (lk_re) lk_rd_r <= link_mem[lk_addr];
  end

  always_ff @(posedge clk) begin
    if (ct_we) cnt_mem[ct_addr] <= ct_wd;
    if (ct_re) ct_rd_r <= cnt_mem[ct_addr];
  end

  eng_state_t          state_r, state_nxt;
  links_t              root_r, root_nxt;
  logic [NODE_W-1:0]   nf_r, nf_nxt;
  logic [CNT_W-1:0]    keys_r, keys_nxt;
  logic                phase_r, phase_nxt;
  logic                at_root_r, at_root_nxt;
  logic                pend_r, pend_nxt;
  logic [LVL_W-1:0]    lvl_r, lvl_nxt;
  logic [CNT_W-1:0]    acc_r, acc_nxt;
  logic [CNT_W-1:0]    hi_r, hi_nxt;
  logic [CNT_W-1:0]    lo_r, lo_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [NODE_W-1:0]   idx_r, idx_nxt;
  logic                full_r, full_nxt;

  logic [LIM_W-1:0]    lim_sel;
  logic [LX_W-1:0]     lim_ext;
  logic [KEY_BITS-1:0] lim_k;
  logic                lim_full;
  links_t              cur_links;
  links_t              new_links;
  logic                t_bit, l_bit;
  logic [NODE_W-1:0]   same_nd, other_nd, next_nd, alloc_nd;
  logic [CNT_W-1:0]    acc_sum;
  logic [LVL_W-1:0]    lvl_dn;

  always_comb begin
    state_nxt   = state_r;
    root_nxt    = root_r;
    nf_nxt      = nf_r;
    keys_nxt    = keys_r;
    phase_nxt   = phase_r;
    at_root_nxt = at_root_r;
    pend_nxt    = pend_r;
    lvl_nxt     = lvl_r;
    acc_nxt     = acc_r;
    hi_nxt      = hi_r;
    lo_nxt      = lo_r;
    key_nxt     = key_r;
    idx_nxt     = idx_r;
    full_nxt    = full_r;
    lk_we = 1'b0; lk_re = 1'b0; lk_addr = '0; lk_wd = '0;
    ct_we = 1'b0; ct_re = 1'b0; ct_addr = '0; ct_wd = '0;

    lim_sel  = phase_r ? {1'b0, cmd.lo_lim} : cmd.hi_lim;
    lim_ext  = LX_W'(lim_sel);
    lim_k    = lim_ext[KEY_BITS-1:0];
    // A limit of 2^KEY_BITS or more puts every stored key below it.
    lim_full = (LIM_W > KEY_BITS) && ((lim_sel >> KEY_BITS) != '0);

    cur_links = at_root_r ? root_r : lk_rd_r;
    t_bit     = key_r[lvl_r];
    l_bit     = lim_k[lvl_r];
    same_nd   = cur_links[t_bit];
    other_nd  = cur_links[~t_bit];
    next_nd   = l_bit ? other_nd : same_nd;
    acc_sum   = acc_r + (pend_r ? ct_rd_r : '0);
    alloc_nd  = nf_r + NODE_W'(1);
    lvl_dn    = lvl_r - LVL_W'(1);
    new_links = '0;

    case (state_r)
      S_IDLE: begin
        if (cmd.start) begin
          key_nxt   = key;
          phase_nxt = 1'b0;
          full_nxt  = 1'b0;
          state_nxt = S_SETUP;
          if (cmd.restart) begin
            root_nxt = '0;
            nf_nxt   = '0;
            keys_nxt = '0;
          end
        end
      end
      S_SETUP: begin
        if (lim_full) begin
          if (!phase_r) begin
            hi_nxt    = keys_r;
            phase_nxt = 1'b1;
          end else begin
            lo_nxt    = keys_r;
            state_nxt = S_INSCHK;
          end
        end else begin
          lvl_nxt     = TOP_LVL;
          at_root_nxt = 1'b1;
          acc_nxt     = '0;
          pend_nxt    = 1'b0;
          state_nxt   = S_WALK;
        end
      end
      S_WALK: begin
        // Count the subtree on the same side when the limit bit is one, follow the other.
        acc_nxt  = acc_sum;
        pend_nxt = l_bit && (same_nd != '0);
        if (pend_nxt) begin
          ct_re   = 1'b1;
          ct_addr = node_addr(same_nd);
        end
        if ((next_nd == '0) || (lvl_r == '0)) begin
          state_nxt = S_WTAIL;
        end else begin
          lk_re       = 1'b1;
          lk_addr     = node_addr(next_nd);
          lvl_nxt     = lvl_dn;
          at_root_nxt = 1'b0;
        end
      end
      S_WTAIL: begin
        pend_nxt = 1'b0;
        if (!phase_r) begin
          hi_nxt    = acc_sum;
          phase_nxt = 1'b1;
          state_nxt = S_SETUP;
        end else begin
          lo_nxt    = acc_sum;
          state_nxt = S_INSCHK;
        end
      end
      S_INSCHK: begin
        if (keys_r >= CNT_W'(MAX_ITEMS)) begin
          full_nxt  = 1'b1;
          state_nxt = S_DONE;
        end else begin
          lvl_nxt     = TOP_LVL;
          at_root_nxt = 1'b1;
          state_nxt   = S_INS;
        end
      end
      S_INS: begin
        if (same_nd != '0) begin
          lk_re     = 1'b1;
          lk_addr   = node_addr(same_nd);
          ct_re     = 1'b1;
          ct_addr   = node_addr(same_nd);
          idx_nxt   = same_nd;
          state_nxt = S_UPD;
        end else begin
          // The path ends here: hook the first new node onto the parent.
          if (at_root_r) begin
            root_nxt[t_bit] = alloc_nd;
          end else begin
            new_links        = cur_links;
            new_links[t_bit] = alloc_nd;
            lk_we            = 1'b1;
            lk_addr          = node_addr(idx_r);
            lk_wd            = new_links;
          end
          state_nxt = S_ALLOC;
        end
      end
      S_UPD: begin
        ct_we   = 1'b1;
        ct_addr = node_addr(idx_r);
        ct_wd   = ct_rd_r + CNT_W'(1);
        if (lvl_r == '0) begin
          keys_nxt  = keys_r + CNT_W'(1);
          state_nxt = S_DONE;
        end else begin
          lvl_nxt     = lvl_dn;
          at_root_nxt = 1'b0;
          state_nxt   = S_INS;
        end
      end
      S_ALLOC: begin
        // New nodes are numbered consecutively, each linking to the next one.
        nf_nxt  = alloc_nd;
        if (lvl_r != '0) begin
          new_links[key_r[lvl_dn]] = alloc_nd + NODE_W'(1);
        end
        lk_we   = 1'b1;
        lk_addr = node_addr(alloc_nd);
        lk_wd   = new_links;
        ct_we   = 1'b1;
        ct_addr = node_addr(alloc_nd);
        ct_wd   = CNT_W'(1);
        if (lvl_r == '0) begin
          keys_nxt  = keys_r + CNT_W'(1);
          state_nxt = S_DONE;
        end else begin
          lvl_nxt = lvl_dn;
        end
      end
      S_DONE: begin
        if (cmd.res_ack) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      root_r    <= '0;
      nf_r      <= '0;
      keys_r    <= '0;
      phase_r   <= 1'b0;
      at_root_r <= 1'b1;
      pend_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      root_r    <= root_nxt;
      nf_r      <= nf_nxt;
      keys_r    <= keys_nxt;
      phase_r   <= phase_nxt;
      at_root_r <= at_root_nxt;
      pend_r    <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lvl_r  <= lvl_nxt;
    acc_r  <= acc_nxt;
    hi_r   <= hi_nxt;
    lo_r   <= lo_nxt;
    key_r  <= key_nxt;
    idx_r  <= idx_nxt;
    full_r <= full_nxt;
  end

  assign stat.idle = (state_r == S_IDLE);
  assign stat.done = (state_r == S_DONE);
  assign stat.full = full_r;
  assign hi_cnt    = hi_r;
  assign lo_cnt    = lo_r;

endmodule

[sv/xor_range_pair_counter.sv]
// XOR range pair counter, top level: channels, bound registers, pair total, result register.
// Depends on xrpc_pkg, the interfaces in xrpc_ifs.sv and xrpc_trie_engine.
//
// Use: keys arrive as items on in_ch (key_value, restart). For each key the block counts
// the earlier keys since the last restart whose XOR with it lies in [low_bound, high_bound],
// then stores the key in a binary trie. One result item per key leaves on out_ch:
// pair_count, the saturating running total_pairs, and store_full when MAX_ITEMS keys are
// already held and the key was not stored. A restart flag empties the trie and the total
// before its own key is processed. The user must write bounds on cfg_ch (index 0 low_bound,
// index 1 high_bound) only while no item is in flight; unenforced: cfg_ch is always ready.
//
// Timing: one item at a time. Each item runs two range walks, one node per cycle, and then,
// unless the store is full, an insertion that reads and then updates each existing node on
// its path and writes each new node, through the single port of each node memory. in_ch is
// ready again the cycle after the result moves into the output register, even while that
// result still waits for the receiver. If the receiver stalls with a result held, the
// engine keeps its finished result and waits. Reset empties the trie, clears the total and
// the output valid flag and loads the bounds with 1 and 65535; node memory contents are
// not cleared, since every node is written when it is allocated.
module xor_range_pair_counter import xrpc_pkg::*; #(
  parameter int KEY_BITS  = 16,
  parameter int MAX_ITEMS = 1024
) (
  input logic        clk,
  input logic        rst_n,
  xrpc_in_if.sink    in_ch,
  xrpc_out_if.source out_ch,
  xrpc_cfg_if.sink   cfg_ch
);

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int KX_W  = (KEY_BITS > KEY_W) ? KEY_BITS : KEY_W;
  localparam int PCX_W = (CNT_W > CNT_OUT_W) ? CNT_W : CNT_OUT_W;
  localparam int SUM_W = ((CNT_W > TOT_W) ? CNT_W : TOT_W) + 1;

  logic [BOUND_W-1:0]   low_r, high_r;
  logic [TOT_W-1:0]     total_r;
  logic                 out_valid_r;
  logic [CNT_OUT_W-1:0] pc_out_r;
  logic [TOT_W-1:0]     tot_out_r;
  logic                 full_out_r;

  xrpc_cmd_t            cmd;
  xrpc_stat_t           stat;
  logic [CNT_W-1:0]     hi_cnt, lo_cnt;
  logic [KX_W-1:0]      key_ext;
  logic [KEY_BITS-1:0]  key_k;
  logic                 in_take, res_take;
  logic [CNT_W-1:0]     pc_full;
  logic [PCX_W-1:0]     pc_ext;
  logic [SUM_W-1:0]     sum;
  logic [TOT_W-1:0]     total_nxt;

  // Bound registers. Writes are accepted at any time.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r  <= LOW_RESET;
      high_r <= HIGH_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_LOW_BOUND:  low_r  <= cfg_ch.data;
        REG_HIGH_BOUND: high_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Only the low KEY_BITS bits of the key take part; wider tries see zero-extended keys.
  assign key_ext = KX_W'(in_ch.key_value);
  assign key_k   = key_ext[KEY_BITS-1:0];

  assign in_ch.ready = stat.idle;
  assign in_take     = in_ch.valid && stat.idle;
  assign res_take    = stat.done && (!out_valid_r || out_ch.ready);

  // The upper limit carries one extra bit so that a high bound of all ones works.
  assign cmd.start   = in_take;
  assign cmd.restart = in_ch.restart;
  assign cmd.res_ack = res_take;
  assign cmd.hi_lim  = {1'b0, high_r} + LIM_W'(1);
  assign cmd.lo_lim  = low_r;

  xrpc_trie_engine #(
    .KEY_BITS  (KEY_BITS),
    .MAX_ITEMS (MAX_ITEMS)
  ) u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .key    (key_k),
    .stat   (stat),
    .hi_cnt (hi_cnt),
    .lo_cnt (lo_cnt)
  );

  // An empty range (low bound above the upper limit) counts nothing.
  assign pc_full   = (hi_cnt > lo_cnt) ? (hi_cnt - lo_cnt) : '0;
  assign pc_ext    = PCX_W'(pc_full);
  assign sum       = SUM_W'(total_r) + SUM_W'(pc_full);
  assign total_nxt = (sum > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else if (in_take && in_ch.restart) begin
      total_r <= '0;
    end else if (res_take) begin
      total_r <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      pc_out_r   <= pc_ext[CNT_OUT_W-1:0];
      tot_out_r  <= total_nxt;
      full_out_r <= stat.full;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.pair_count  = pc_out_r;
  assign out_ch.total_pairs = tot_out_r;
  assign out_ch.store_full  = full_out_r;

endmodule

[sv/xrpc_checker.sv]
// Port-level checks of the XOR range pair counter, bound to the top level.
// Depends on xrpc_pkg and xor_range_pair_counter.
module xrpc_checker import xrpc_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [CNT_OUT_W-1:0] pair_count,
  input logic [TOT_W-1:0]     total_pairs,
  input logic                 store_full
);

  // A stalled result keeps its fields.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(pair_count) &&
      $stable(total_pairs) && $stable(store_full))
    else $error("result changed while stalled");

  // Only one item is worked on at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an accepted item");

  // The running total includes this item's count.
  a_total_covers: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> total_pairs >= TOT_W'(pair_count))
    else $error("total below pair count");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind xor_range_pair_counter xrpc_checker u_xrpc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .pair_count  (out_ch.pair_count),
  .total_pairs (out_ch.total_pairs),
  .store_full  (out_ch.store_full)
);
